[rtl/vcrd_pkg.sv]
// vcrd_pkg: shared types, constants and helpers for the voxel column run decoder
// no dependencies; used by every rtl file of the block
`default_nettype none

package vcrd_pkg;

	localparam int unsigned CFG_W       = 9;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned ADDR_W      = 24;
	localparam int unsigned DEF_MAX_DIM = 256;

	localparam logic [CFG_IDX_W-1:0] CFG_VOL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOL_DEPTH  = 2'd2;

	localparam logic [CFG_W-1:0]  CFG_RESET = 9'd1;
	localparam logic [CFG_W-1:0]  X_MAX     = 9'd511;
	localparam logic [ADDR_W-1:0] LAYER_MAX = 24'hFF_FFFF;

	localparam logic [7:0] ALPHA_RUN  = 8'd2;
	localparam logic [7:0] ALPHA_SKIP = 8'd0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] voxel_address;
		logic [7:0]        run_length;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic              solid;
		logic              beyond_volume;
	} out_item_t;

	// one write run as seen by the parser, before address math
	typedef struct packed {
		logic [ADDR_W-1:0] layer;
		logic [CFG_W-1:0]  col_x;
		logic [CFG_W-1:0]  col_z;
		logic [7:0]        len;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic              solid;
	} run_rec_t;

	// clamped volume dimensions
	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic [CFG_W-1:0] depth;
	} dims_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
	                                               input int unsigned max_dim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > max_dim) begin
			r = CFG_W'(max_dim);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/voxel_column_rle_decoder.sv]
// voxel_column_rle_decoder: top level, volume registers, parser and address unit
// depends on vcrd_pkg, vcrd_parser, vcrd_addr
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data (data_byte, last_byte)
//   out     | output    | out_valid / out_ready| out_data (address, length, colour, flags)
//   cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// one stream byte per cycle while in_ready is high
// the parser state and run register, then the two address stages, form the path
// reset sets all volume sizes to 1 and the parser to the column count low byte
// three run slots absorb output stalls; in_ready drops only when all three are full
`default_nettype none

module voxel_column_rle_decoder #(
	parameter int unsigned MAX_DIM = vcrd_pkg::DEF_MAX_DIM
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  vcrd_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  wire                            out_ready,
	output vcrd_pkg::out_item_t            out_data,
	input  wire                            cfg_we,
	input  wire  [vcrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [vcrd_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [vcrd_pkg::CFG_W-1:0] vol_width_q, vol_height_q, vol_depth_q;
	vcrd_pkg::dims_t            dims;
	logic                       run_valid, run_ready;
	vcrd_pkg::run_rec_t         run_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q  <= vcrd_pkg::CFG_RESET;
			vol_height_q <= vcrd_pkg::CFG_RESET;
			vol_depth_q  <= vcrd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vcrd_pkg::CFG_VOL_WIDTH:  vol_width_q  <= cfg_wdata;
				vcrd_pkg::CFG_VOL_HEIGHT: vol_height_q <= cfg_wdata;
				vcrd_pkg::CFG_VOL_DEPTH:  vol_depth_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign dims.width  = vcrd_pkg::clamp_dim(vol_width_q, MAX_DIM);
	assign dims.height = vcrd_pkg::clamp_dim(vol_height_q, MAX_DIM);
	assign dims.depth  = vcrd_pkg::clamp_dim(vol_depth_q, MAX_DIM);

	vcrd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.depth     (dims.depth),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run_data  (run_data)
	);

	vcrd_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run_data  (run_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[rtl/vcrd_parser.sv]
// vcrd_parser: byte-level column/command parser with a one-entry run register (s1)
// depends on vcrd_pkg
`default_nettype none

module vcrd_parser (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  vcrd_pkg::in_item_t         in_data,
	input  wire  [vcrd_pkg::CFG_W-1:0] depth,
	output logic                       run_valid,
	input  wire                        run_ready,
	output vcrd_pkg::run_rec_t         run_data
);

	localparam logic [1:0] PH_CNT_LO = 2'd0;
	localparam logic [1:0] PH_CNT_HI = 2'd1;
	localparam logic [1:0] PH_CMD    = 2'd2;
	localparam logic [1:0] PH_COLOR  = 2'd3;

	logic [1:0]                  phase_q, phase_n;
	logic [1:0]                  biw_q, biw_n;
	logic [7:0]                  count_low_q, count_low_n;
	logic [15:0]                 words_left_q, words_left_n, wl_dec;
	logic [23:0]                 word_bytes_q, word_bytes_n;
	logic [7:0]                  pending_q, pending_n;
	logic [vcrd_pkg::ADDR_W-1:0] layer_q, layer_n, layer_sat;
	logic [vcrd_pkg::ADDR_W:0]   layer_sum;
	logic [7:0]                  add_amt;
	logic [vcrd_pkg::CFG_W-1:0]  col_x_q, col_x_n, col_z_q, col_z_n;
	logic                        end_col, emit;
	logic                        take;
	vcrd_pkg::run_rec_t          rec_n;
	logic                        valid_s1;
	vcrd_pkg::run_rec_t          rec_s1;

	assign in_ready = !valid_s1 || run_ready;
	assign take     = in_valid && in_ready;
	assign wl_dec   = (words_left_q != '0) ? words_left_q - 16'd1 : '0;
	assign add_amt  = (phase_q == PH_COLOR) ? pending_q : 8'd1;
	assign layer_sum = {1'b0, layer_q} + (vcrd_pkg::ADDR_W + 1)'(add_amt);
	assign layer_sat = layer_sum[vcrd_pkg::ADDR_W] ? vcrd_pkg::LAYER_MAX
	                                               : layer_sum[vcrd_pkg::ADDR_W-1:0];

	always_comb begin
		phase_n      = phase_q;
		biw_n        = biw_q;
		count_low_n  = count_low_q;
		words_left_n = words_left_q;
		word_bytes_n = word_bytes_q;
		pending_n    = pending_q;
		layer_n      = layer_q;
		col_x_n      = col_x_q;
		col_z_n      = col_z_q;
		end_col      = 1'b0;
		emit         = 1'b0;

		rec_n.layer = layer_q;
		rec_n.col_x = col_x_q;
		rec_n.col_z = col_z_q;
		rec_n.len   = 8'd1;
		rec_n.red   = word_bytes_q[7:0];
		rec_n.green = word_bytes_q[15:8];
		rec_n.blue  = word_bytes_q[23:16];
		rec_n.solid = 1'b1;

		unique case (phase_q)
			PH_CNT_LO: begin
				count_low_n = in_data.data_byte;
				phase_n     = PH_CNT_HI;
			end
			PH_CNT_HI: begin
				words_left_n = {in_data.data_byte, count_low_q};
				biw_n        = '0;
				layer_n      = '0;
				if ({in_data.data_byte, count_low_q} == 16'd0) begin
					end_col = 1'b1;
				end else begin
					phase_n = PH_CMD;
				end
			end
			PH_CMD, PH_COLOR: begin
				if (biw_q != 2'd3) begin
					word_bytes_n = word_bytes_q | (24'(in_data.data_byte) << {biw_q, 3'b000});
					biw_n        = biw_q + 2'd1;
				end else begin
					biw_n        = '0;
					words_left_n = wl_dec;
					word_bytes_n = '0;
					if (phase_q == PH_CMD) begin
						if (in_data.data_byte == vcrd_pkg::ALPHA_RUN) begin
							pending_n = word_bytes_q[7:0];
							phase_n   = PH_COLOR;
						end else begin
							emit    = (in_data.data_byte != vcrd_pkg::ALPHA_SKIP);
							layer_n = layer_sat;
							end_col = (wl_dec == '0);
						end
					end else begin
						rec_n.len   = pending_q;
						rec_n.solid = (in_data.data_byte != 8'd0);
						emit        = (pending_q != '0);
						if (pending_q != '0) begin
							layer_n = layer_sat;
						end
						pending_n = '0;
						if (wl_dec == '0) begin
							end_col = 1'b1;
						end else begin
							phase_n = PH_CMD;
						end
					end
				end
			end
			default: begin
				phase_n = PH_CNT_LO;
			end
		endcase

		if (end_col) begin
			if ({1'b0, col_z_q} + 10'd1 >= {1'b0, depth}) begin
				col_z_n = '0;
				if (col_x_q < vcrd_pkg::X_MAX) begin
					col_x_n = col_x_q + 9'd1;
				end
			end else begin
				col_z_n = col_z_q + 9'd1;
			end
			layer_n = '0;
			phase_n = PH_CNT_LO;
		end

		// end of stream: drop any partial column and restart at the first column
		if (in_data.last_byte) begin
			phase_n      = PH_CNT_LO;
			biw_n        = '0;
			count_low_n  = '0;
			words_left_n = '0;
			word_bytes_n = '0;
			pending_n    = '0;
			layer_n      = '0;
			col_x_n      = '0;
			col_z_n      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CNT_LO;
			biw_q        <= '0;
			count_low_q  <= '0;
			words_left_q <= '0;
			word_bytes_q <= '0;
			pending_q    <= '0;
			layer_q      <= '0;
			col_x_q      <= '0;
			col_z_q      <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (take) begin
				phase_q      <= phase_n;
				biw_q        <= biw_n;
				count_low_q  <= count_low_n;
				words_left_q <= words_left_n;
				word_bytes_q <= word_bytes_n;
				pending_q    <= pending_n;
				layer_q      <= layer_n;
				col_x_q      <= col_x_n;
				col_z_q      <= col_z_n;
			end
			if (take && emit) begin
				valid_s1 <= 1'b1;
			end else if (run_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			rec_s1 <= rec_n;
		end
	end

	assign run_valid = valid_s1;
	assign run_data  = rec_s1;

endmodule

`default_nettype wire

[rtl/vcrd_addr.sv]
// vcrd_addr: two-stage address and bounds unit (s2 partial products, s3 result register)
// depends on vcrd_pkg
`default_nettype none

module vcrd_addr (
	input  wire                 clk,
	input  wire                 arst_n,
	input  vcrd_pkg::dims_t     dims,
	input  wire                 run_valid,
	output logic                run_ready,
	input  vcrd_pkg::run_rec_t  run_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output vcrd_pkg::out_item_t out_data
);

	localparam int unsigned AW = vcrd_pkg::ADDR_W;

	logic              valid_s2, valid_s3;
	logic              adv_s2, adv_s3;
	logic [AW-1:0]     lw_n, zw_n, lw_s2, zw_s2;
	logic [AW+8:0]     lw_full;
	logic [AW+8:0]     lwd_full;
	logic [AW:0]       top_layer;
	logic              beyond_n;
	vcrd_pkg::run_rec_t rec_s2;
	logic              beyond_s2;
	vcrd_pkg::out_item_t out_s3;

	assign adv_s3    = !valid_s3 || out_ready;
	assign adv_s2    = !valid_s2 || adv_s3;
	assign run_ready = adv_s2;

	// layer*width and column offset modulo the address width; bounds without wrap
	assign lw_full   = (AW + 9)'(run_data.layer) * (AW + 9)'(dims.width);
	assign lw_n      = lw_full[AW-1:0];
	assign zw_n      = AW'(run_data.col_z) * AW'(dims.width) + AW'(dims.width)
	                   - AW'(1) - AW'(run_data.col_x);
	assign top_layer = {1'b0, run_data.layer} + (AW + 1)'(run_data.len);
	assign beyond_n  = (run_data.col_x >= dims.width) || (run_data.col_z >= dims.depth)
	                   || (top_layer > (AW + 1)'(dims.height));

	assign lwd_full  = (AW + 9)'(lw_s2) * (AW + 9)'(dims.depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= run_valid;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && run_valid) begin
			rec_s2    <= run_data;
			lw_s2     <= lw_n;
			zw_s2     <= zw_n;
			beyond_s2 <= beyond_n;
		end
		if (adv_s3 && valid_s2) begin
			out_s3.voxel_address <= lwd_full[AW-1:0] + zw_s2;
			out_s3.run_length    <= rec_s2.len;
			out_s3.red           <= rec_s2.red;
			out_s3.green         <= rec_s2.green;
			out_s3.blue          <= rec_s2.blue;
			out_s3.solid         <= rec_s2.solid;
			out_s3.beyond_volume <= beyond_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = out_s3;

endmodule

`default_nettype wire

[rtl/vcrd_checker.sv]
// vcrd_checker: port-level checks for the voxel column run decoder, bound to the top level
// depends on vcrd_pkg and voxel_column_rle_decoder
`default_nettype none

module vcrd_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_ready,
	input vcrd_pkg::in_item_t             in_data,
	input wire                            out_valid,
	input wire                            out_ready,
	input vcrd_pkg::out_item_t            out_data
);

	// result held until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed before transfer");

	// offered byte held until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed before transfer");

	// nothing pending out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	// zero-count runs never leave the block
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.run_length != 8'd0)
		else $error("run of length zero");

	// with the output empty the pipe cannot be full
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind voxel_column_rle_decoder vcrd_checker u_vcrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
